### design/ang_pkg.sv
// Package for the audio noise gate: widths, register indexes, reset values,
// gate phase codes and the payload, configuration and command structs.
// No dependencies.
package ang_pkg;

	// Field widths
	localparam int SAMPLE_BITS   = 24;
	localparam int COEFF_BITS    = 16;
	localparam int HOLD_BITS     = 17;
	localparam int GAIN_BITS     = COEFF_BITS + 1;
	localparam int PHASE_BITS    = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	// Gain constants, Q1.COEFF_BITS
	localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << COEFF_BITS);
	localparam logic [GAIN_BITS-1:0] SNAP_HI  =
		GAIN_BITS'((1 << COEFF_BITS) - (1 << COEFF_BITS) / 1000);
	localparam logic [GAIN_BITS-1:0] SNAP_LO  = GAIN_BITS'((1 << COEFF_BITS) / 1000);

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENV_DECAY = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD      = 3'd4;

	// Register reset values
	localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(8389);
	localparam logic [COEFF_BITS-1:0]  ATTACK_RST    = COEFF_BITS'(64228);
	localparam logic [COEFF_BITS-1:0]  RELEASE_RST   = COEFF_BITS'(65509);
	localparam logic [COEFF_BITS-1:0]  ENV_DECAY_RST = COEFF_BITS'(65454);
	localparam logic [HOLD_BITS-1:0]   HOLD_RST      = HOLD_BITS'(2400);

	// Gate phase codes
	typedef enum logic [PHASE_BITS-1:0] {
		PH_CLOSED  = 3'd0,
		PH_OPENING = 3'd1,
		PH_OPEN    = 3'd2,
		PH_HOLDING = 3'd3,
		PH_CLOSING = 3'd4
	} gate_phase_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          block_end_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [GAIN_BITS-1:0]          gain_now;
		logic [PHASE_BITS-1:0]         gate_phase;
		logic                          block_end_out;
	} out_item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] threshold_level;
		logic [COEFF_BITS-1:0]  attack_coeff;
		logic [COEFF_BITS-1:0]  release_coeff;
		logic [COEFF_BITS-1:0]  envelope_decay_coeff;
		logic [HOLD_BITS-1:0]   hold_length;
	} cfg_regs_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic env_step;
		logic gain_step;
		logic scale_step;
		logic out_load;
	} dp_cmd_t;

endpackage

### design/audio_noise_gate_core.sv
// Audio noise gate with hold: configuration registers, controller and datapath.
// Depends on ang_pkg, ang_ctrl and ang_dp.
//
// Usage:
// - Input channel in_valid/in_ready/in_data carries one signed sample and a
//   block-end mark per transaction; output channel out_valid/out_ready/out_data
//   returns one scaled sample with the gain and gate phase after its update.
// - Each transaction steps through accept, envelope update, gain and phase
//   update and output scaling. The three multiplications share one multiplier;
//   in_ready is high only while idle, so no new sample is taken until the
//   previous one has been scaled and loaded into the output register.
// - The result sits in an output register, so a new sample is accepted while
//   the previous result waits; if the receiver still stalls when the next
//   result is ready, the controller holds in its scale cycle until it drains.
// - Registers are written through cfg_we/cfg_index/cfg_data; write them only
//   while idle (not enforced by the block); out-of-range indexes are ignored.
// - Reset (arst_n low) restores register defaults, closes the gate with zero
//   gain, envelope and hold count, and empties the output register.
module audio_noise_gate_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ang_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ang_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [ang_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [ang_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import ang_pkg::*;

	cfg_regs_t cfg_q;
	dp_cmd_t   cmd;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_level      <= THRESHOLD_RST;
			cfg_q.attack_coeff         <= ATTACK_RST;
			cfg_q.release_coeff        <= RELEASE_RST;
			cfg_q.envelope_decay_coeff <= ENV_DECAY_RST;
			cfg_q.hold_length          <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold_level      <= cfg_data[SAMPLE_BITS-1:0];
				REG_ATTACK:    cfg_q.attack_coeff         <= cfg_data[COEFF_BITS-1:0];
				REG_RELEASE:   cfg_q.release_coeff        <= cfg_data[COEFF_BITS-1:0];
				REG_ENV_DECAY: cfg_q.envelope_decay_coeff <= cfg_data[COEFF_BITS-1:0];
				REG_HOLD:      cfg_q.hold_length          <= cfg_data[HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	ang_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ang_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

### design/ang_ctrl.sv
// Sequencing controller for the noise gate: steps each transaction through
// envelope, gain and scale cycles and owns both handshakes.
// Depends on ang_pkg.
module ang_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output ang_pkg::dp_cmd_t cmd
);
	import ang_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ENV   = 4'b0010,
		ST_GAIN  = 4'b0100,
		ST_SCALE = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	// Output register can take a result when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_ENV;
				end
			end
			ST_ENV: begin
				cmd.env_step = 1'b1;
				state_d      = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain_step = 1'b1;
				state_d       = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale_step = 1'b1;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/ang_dp.sv
// Datapath for the noise gate: sample register, envelope, gate phase, gain and
// hold state, one shared multiplier and the output register.
// Depends on ang_pkg.
module ang_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ang_pkg::dp_cmd_t  cmd,
	input  ang_pkg::cfg_regs_t cfg,
	input  ang_pkg::in_item_t in_data,
	output ang_pkg::out_item_t out_data
);
	import ang_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 2;
	localparam int RAMP_BITS = COEFF_BITS + GAIN_BITS + 1;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          block_end_q;
	logic [SAMPLE_BITS-1:0]        env_q;
	logic [GAIN_BITS-1:0]          gain_q, gain_d;
	logic [HOLD_BITS-1:0]          hold_q, hold_d;
	gate_phase_t                   phase_q, phase_d;
	out_item_t                     out_q;

	logic signed [SAMPLE_BITS:0]   mul_a;
	logic signed [GAIN_BITS:0]     mul_b;
	logic signed [PROD_BITS-1:0]   prod;
	logic [COEFF_BITS-1:0]         ramp_coeff;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [SAMPLE_BITS-1:0]        env_d;
	logic [RAMP_BITS-1:0]          ramp_sum;
	logic [GAIN_BITS-1:0]          gain_attack, gain_release;
	logic                          above;
	logic                          hold_done;

	// Attack while opening, release otherwise
	assign ramp_coeff = (phase_q == PH_OPENING) ? cfg.attack_coeff : cfg.release_coeff;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.env_step) begin
			mul_a = {1'b0, env_q};
			mul_b = {{(GAIN_BITS + 1 - COEFF_BITS){1'b0}}, cfg.envelope_decay_coeff};
		end else if (cmd.gain_step) begin
			mul_a = {{(SAMPLE_BITS + 1 - COEFF_BITS){1'b0}}, ramp_coeff};
			mul_b = {1'b0, gain_q};
		end else if (cmd.scale_step) begin
			mul_a = {sample_q[SAMPLE_BITS-1], sample_q};
			mul_b = {1'b0, gain_q};
		end
	end

	assign prod = mul_a * mul_b;

	// Peak envelope: jump to magnitude, else decay
	assign mag   = sample_q[SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;
	assign env_d = (mag > env_q) ? mag : prod[COEFF_BITS +: SAMPLE_BITS];
	assign above = (env_q >= cfg.threshold_level);

	// Gain ramps
	assign ramp_sum = prod[RAMP_BITS-1:0]
		+ (RAMP_BITS'(GAIN_ONE - {1'b0, cfg.attack_coeff}) << COEFF_BITS);
	assign gain_attack  = ramp_sum[COEFF_BITS +: GAIN_BITS];
	assign gain_release = prod[COEFF_BITS +: GAIN_BITS];
	assign hold_done    = (hold_q <= HOLD_BITS'(1));

	// Gate phase update
	always_comb begin
		phase_d = phase_q;
		gain_d  = gain_q;
		hold_d  = hold_q;
		unique case (phase_q)
			PH_OPENING: begin
				gain_d = gain_attack;
				if (gain_attack >= SNAP_HI) begin
					gain_d  = GAIN_ONE;
					phase_d = PH_OPEN;
				end
			end
			PH_OPEN: begin
				if (!above) begin
					phase_d = PH_HOLDING;
					hold_d  = cfg.hold_length;
				end
			end
			PH_HOLDING: begin
				if (above) begin
					phase_d = PH_OPEN;
					hold_d  = cfg.hold_length;
				end else begin
					if (hold_q != '0) begin
						hold_d = hold_q - 1'b1;
					end
					if (hold_done) begin
						phase_d = PH_CLOSING;
					end
				end
			end
			PH_CLOSING: begin
				gain_d = gain_release;
				if (gain_release <= SNAP_LO) begin
					gain_d  = '0;
					phase_d = PH_CLOSED;
				end
				// reopening wins over the snap's phase, not its gain
				if (above) begin
					phase_d = PH_OPENING;
					hold_d  = cfg.hold_length;
				end
			end
			default: begin
				phase_d = PH_CLOSED;
				if (above) begin
					phase_d = PH_OPENING;
					hold_d  = cfg.hold_length;
				end
			end
		endcase
	end

	// Gate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q   <= '0;
			gain_q  <= '0;
			hold_q  <= '0;
			phase_q <= PH_CLOSED;
		end else begin
			if (cmd.env_step) begin
				env_q <= env_d;
			end
			if (cmd.gain_step) begin
				gain_q  <= gain_d;
				hold_q  <= hold_d;
				phase_q <= phase_d;
			end
		end
	end

	// Input capture and output register
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q    <= in_data.sample_in;
			block_end_q <= in_data.block_end_in;
		end
		if (cmd.out_load) begin
			out_q.sample_out    <= prod[COEFF_BITS +: SAMPLE_BITS];
			out_q.gain_now      <= gain_q;
			out_q.gate_phase    <= phase_q;
			out_q.block_end_out <= block_end_q;
		end
	end

	assign out_data = out_q;

endmodule

### tb/sv/ang_gate_checker.sv
`timescale 1ns / 1ps
// Result checker for the audio noise gate. It follows the register writes, predicts
// every gated sample and compares it with the output transactions. Depends on ang_pkg.
module ang_gate_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  ang_pkg::in_item_t                   in_data,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  ang_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [ang_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [ang_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output int                                  fail_count,
	output int                                  pending
);
	import ang_pkg::*;

	// Shadow registers and gate state
	cfg_regs_t             gate_cfg;
	gate_phase_t           phase_now;
	logic [SAMPLE_BITS-1:0] env_level;
	logic [GAIN_BITS-1:0]  gain_level;
	logic [HOLD_BITS-1:0]  hold_left;

	out_item_t gated_q[$];
	int        result_no;

	// One sample through the envelope, the gate and the output scaling
	function automatic out_item_t gate_sample(input in_item_t item);
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [SAMPLE_BITS-1:0]        mag;
		logic [63:0]                   acc;
		logic                          above;
		longint                        prod;
		out_item_t                     res;
		smp = item.sample_in;
		mag = smp[SAMPLE_BITS-1] ? -smp : smp;

		// peak envelope: jump up at once, otherwise decay
		if (mag > env_level) begin
			env_level = mag;
		end else begin
			acc = 64'(gate_cfg.envelope_decay_coeff) * 64'(env_level);
			env_level = SAMPLE_BITS'(acc >> COEFF_BITS);
		end
		above = env_level >= gate_cfg.threshold_level;

		case (phase_now)
			PH_OPENING: begin
				acc = 64'(gate_cfg.attack_coeff) * 64'(gain_level)
					+ (64'(GAIN_ONE) - 64'(gate_cfg.attack_coeff)) * 64'(GAIN_ONE);
				gain_level = GAIN_BITS'(acc >> COEFF_BITS);
				if (gain_level >= SNAP_HI) begin
					gain_level = GAIN_ONE;
					phase_now = PH_OPEN;
				end
			end
			PH_OPEN: begin
				if (!above) begin
					phase_now = PH_HOLDING;
					hold_left = gate_cfg.hold_length;
				end
			end
			PH_HOLDING: begin
				if (above) begin
					phase_now = PH_OPEN;
					hold_left = gate_cfg.hold_length;
				end else begin
					// a count of one or zero ends the hold on this sample
					if (hold_left <= 1) phase_now = PH_CLOSING;
					if (hold_left > 0) hold_left = hold_left - 1'b1;
				end
			end
			PH_CLOSING: begin
				acc = 64'(gate_cfg.release_coeff) * 64'(gain_level);
				gain_level = GAIN_BITS'(acc >> COEFF_BITS);
				if (gain_level <= SNAP_LO) begin
					gain_level = '0;
					phase_now = PH_CLOSED;
				end
				// reopening wins over the snap's phase, not its gain
				if (above) begin
					phase_now = PH_OPENING;
					hold_left = gate_cfg.hold_length;
				end
			end
			default: begin
				phase_now = PH_CLOSED;
				if (above) begin
					phase_now = PH_OPENING;
					hold_left = gate_cfg.hold_length;
				end
			end
		endcase

		// floor of sample times gain
		prod = longint'(smp) * longint'(gain_level);
		res.sample_out    = SAMPLE_BITS'(prod >>> COEFF_BITS);
		res.gain_now      = gain_level;
		res.gate_phase    = phase_now;
		res.block_end_out = item.block_end_in;
		return res;
	endfunction

	// Watch the channels and the register port
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		logic      bad;
		if (!arst_n) begin
			gate_cfg.threshold_level      <= THRESHOLD_RST;
			gate_cfg.attack_coeff         <= ATTACK_RST;
			gate_cfg.release_coeff        <= RELEASE_RST;
			gate_cfg.envelope_decay_coeff <= ENV_DECAY_RST;
			gate_cfg.hold_length          <= HOLD_RST;
			phase_now  = PH_CLOSED;
			env_level  = '0;
			gain_level = '0;
			hold_left  = '0;
			gated_q.delete();
			result_no  = 0;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (gated_q.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("result %0d arrived with none outstanding: sample %0d gain %0d phase %0d end %0b",
							result_no, out_data.sample_out, out_data.gain_now,
							out_data.gate_phase, out_data.block_end_out);
				end else begin
					want = gated_q.pop_front();
					bad = (out_data.sample_out !== want.sample_out)
						|| (out_data.gain_now !== want.gain_now)
						|| (out_data.gate_phase !== want.gate_phase)
						|| (out_data.block_end_out !== want.block_end_out);
					if (bad) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("result %0d: want sample %0d gain %0d phase %0d end %0b, got sample %0d gain %0d phase %0d end %0b",
								result_no, want.sample_out, want.gain_now, want.gate_phase,
								want.block_end_out, out_data.sample_out, out_data.gain_now,
								out_data.gate_phase, out_data.block_end_out);
					end
				end
				result_no = result_no + 1;
			end
			if (in_valid && in_ready)
				gated_q.push_back(gate_sample(in_data));
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: gate_cfg.threshold_level      <= cfg_data[SAMPLE_BITS-1:0];
					REG_ATTACK:    gate_cfg.attack_coeff         <= cfg_data[COEFF_BITS-1:0];
					REG_RELEASE:   gate_cfg.release_coeff        <= cfg_data[COEFF_BITS-1:0];
					REG_ENV_DECAY: gate_cfg.envelope_decay_coeff <= cfg_data[COEFF_BITS-1:0];
					REG_HOLD:      gate_cfg.hold_length          <= cfg_data[HOLD_BITS-1:0];
					default: ;
				endcase
			end
			pending = gated_q.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the audio noise gate testbench: clock, reset, sample stimulus, register
// settings and the verdict. Depends on ang_pkg, audio_noise_gate_core and ang_gate_checker.
module tb;
	import ang_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 120;
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	in_item_t                 in_data   = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	out_item_t                out_data;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	int                       fail_count;
	int                       pending;

	logic [SAMPLE_BITS-1:0] cur_thr = THRESHOLD_RST;
	logic                   tx_calm = 1'b0;
	int                     idle_cycles = 0;
	int                     calm_left = 0;
	int                     stall_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	audio_noise_gate_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ang_gate_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver: mostly ready, short and occasional long stalls, calm stretches
	always @(negedge clk) begin
		int r;
		if (calm_left > 0) begin
			calm_left = calm_left - 1;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				calm_left = $urandom_range(20, 200);
				out_ready <= 1'b1;
			end else if (r < 65) begin
				out_ready <= 1'b1;
			end else if (r < 95) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				stall_left = $urandom_range(10, 50);
				out_ready <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any transaction or register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Magnitude at or above the threshold, random sign
	function automatic logic [SAMPLE_BITS-1:0] loud_sample();
		logic [SAMPLE_BITS-1:0] mag;
		if (cur_thr > FULL_SCALE_POS || $urandom_range(0, 31) == 0) return FULL_SCALE_NEG;
		mag = cur_thr + SAMPLE_BITS'($urandom_range(0, FULL_SCALE_POS - cur_thr));
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Small magnitude well under the threshold
	function automatic logic [SAMPLE_BITS-1:0] quiet_sample();
		logic [SAMPLE_BITS-1:0] cap;
		logic [SAMPLE_BITS-1:0] mag;
		cap = cur_thr >> 3;
		if (cap > 4000) cap = 4000;
		mag = SAMPLE_BITS'($urandom_range(0, cap));
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Present one sample and hold it until the transaction completes
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic blk_end,
		input int gap);
		in_item_t item;
		item.sample_in    = smp;
		item.block_end_in = blk_end;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain_gate();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write; bits above the register width carry junk
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value, input int width);
		logic [CFG_DATA_BITS-1:0] data;
		logic [CFG_DATA_BITS-1:0] mask;
		mask = CFG_DATA_BITS'((64'd1 << width) - 64'd1);
		data = (CFG_DATA_BITS'($urandom) & ~mask) | (value & mask);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	task automatic program_gate(input cfg_regs_t c);
		drain_gate();
		cur_thr = c.threshold_level;
		write_reg(REG_THRESHOLD, CFG_DATA_BITS'(c.threshold_level), SAMPLE_BITS);
		write_reg(REG_ATTACK, CFG_DATA_BITS'(c.attack_coeff), COEFF_BITS);
		write_reg(REG_RELEASE, CFG_DATA_BITS'(c.release_coeff), COEFF_BITS);
		write_reg(REG_ENV_DECAY, CFG_DATA_BITS'(c.envelope_decay_coeff), COEFF_BITS);
		write_reg(REG_HOLD, CFG_DATA_BITS'(c.hold_length), HOLD_BITS);
		// indexes past the last register must be ignored
		write_reg(REG_HOLD + CFG_IDX_BITS'($urandom_range(1, 3)), '0, 0);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		cfg_regs_t c;
		int n;
		int kind;
		int len;
		logic [SAMPLE_BITS-1:0] smp;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Field extremes at the reset settings
		send_sample('0, 1'b0, 0);
		send_sample(FULL_SCALE_POS, 1'b1, 0);
		send_sample(FULL_SCALE_NEG, 1'b0, 0);
		send_sample('1, 1'b1, 1);

		// Instant ramps, no envelope memory, zero hold
		c.threshold_level      = SAMPLE_BITS'(1000);
		c.attack_coeff         = '0;
		c.release_coeff        = '0;
		c.envelope_decay_coeff = '0;
		c.hold_length          = '0;
		program_gate(c);
		send_sample(SAMPLE_BITS'(5000), 1'b0, 0);   // open
		send_sample('0, 1'b0, 0);                   // holding, zero count
		send_sample('0, 1'b0, 0);                   // closing
		send_sample(SAMPLE_BITS'(5000), 1'b0, 0);   // snap to zero, yet reopen
		send_sample(SAMPLE_BITS'(5000), 1'b1, 0);   // open
		send_sample('0, 1'b0, 0);                   // holding
		send_sample(SAMPLE_BITS'(-5000), 1'b0, 0);  // back to open
		send_sample('0, 1'b0, 0);
		send_sample('0, 1'b0, 0);                   // closing
		send_sample('0, 1'b0, 0);                   // closed
		send_sample('0, 1'b1, 0);

		// Zero threshold with full-scale ramps: gate opens, gain stalls short of unity
		c.threshold_level = '0;
		c.attack_coeff    = '1;
		c.release_coeff   = '1;
		program_gate(c);
		send_sample('0, 1'b0, 0);
		send_sample('0, 1'b0, 0);

		// Random phases: bursts and quiet stretches under varied settings
		for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
			case (phase_no)
				0: begin
					// top threshold is met only by the most negative sample
					c.threshold_level      = FULL_SCALE_NEG;
					c.attack_coeff         = '1;
					c.release_coeff        = '1;
					c.envelope_decay_coeff = '1;
					c.hold_length          = '1;
				end
				1: begin
					c = '0;
				end
				default: begin
					c.threshold_level = ($urandom_range(0, 5) == 0)
						? SAMPLE_BITS'($urandom_range(0, FULL_SCALE_NEG))
						: SAMPLE_BITS'($urandom_range(200, 200000));
					c.attack_coeff = ($urandom_range(0, 7) == 0)
						? '0 : COEFF_BITS'($urandom_range(20000, 65500));
					c.release_coeff        = COEFF_BITS'($urandom_range(20000, 65000));
					c.envelope_decay_coeff = COEFF_BITS'($urandom_range(30000, 65400));
					c.hold_length = ($urandom_range(0, 3) == 0)
						? HOLD_BITS'($urandom_range(0, 300)) : HOLD_BITS'($urandom_range(0, 20));
				end
			endcase
			program_gate(c);

			n = 0;
			while (n < PHASE_ITEMS) begin
				kind    = $urandom_range(0, 99);
				tx_calm = ($urandom_range(0, 4) == 0);
				if (kind < 45) len = $urandom_range(1, 8);
				else if (kind < 90) len = $urandom_range(1, 40);
				else len = $urandom_range(1, 5);
				for (int k = 0; k < len && n < PHASE_ITEMS; k++) begin
					if (kind < 45) smp = loud_sample();
					else if (kind < 90) smp = quiet_sample();
					else smp = SAMPLE_BITS'($urandom);
					// now and then the sender waits for the gate to empty
					if ($urandom_range(0, 99) == 0) drain_gate();
					send_sample(smp, ($urandom_range(0, 7) == 0), pick_gap());
					n = n + 1;
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
